// ===== design/iee_pkg.sv =====
package iee_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_OPEN = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_STACK    = 2'd2,
        ST_BAD_CHAR = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_OP_LOOP,
        S_CLOSE_LOOP,
        S_FIN_LOOP,
        S_RED_POP,
        S_RED_EXEC,
        S_DIV_RUN,
        S_FIN_CHECK,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        K_OPER,
        K_CLOSE,
        K_FIN
    } t_kind;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2a;
    localparam logic [7:0] CH_ADD   = 8'h2b;
    localparam logic [7:0] CH_SUB   = 8'h2d;
    localparam logic [7:0] CH_DIV   = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic       load_char;
        logic       acc_digit;
        logic       flush_num;
        logic       push_op;
        logic       pop_op;
        logic       red_pop;
        logic       red_exec;
        logic       div_start;
        logic       div_push;
        logic       set_err;
        t_status    err_code;
        logic       emit;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic       is_digit;
        t_op        char_op;
        logic       is_hash;
        logic       is_close;
        logic       bad_char;
        logic       num_pending;
        logic       err_any;
        logic       op_empty;
        logic       op_full;
        t_op        op_top;
        logic       val_lt2;
        logic       val_full;
        logic       val_one;
        logic       div_zero;
        logic       div_done;
        t_op        red_op;
    } t_stat;

    function automatic logic [1:0] prec(input t_op op);
        logic [1:0] p;
        p = 2'd0;
        if (op == OP_MUL || op == OP_DIV) p = 2'd2;
        else if (op == OP_ADD || op == OP_SUB) p = 2'd1;
        return p;
    endfunction

endpackage

// ===== design/iee_div.sv =====
module iee_div import iee_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_a,
    input  logic [VALUE_WIDTH-1:0] i_b,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_q
);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_q, r_d, r_r;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy, r_neg;
    logic [VALUE_WIDTH:0]   w_rem, w_sub;

    assign w_rem = {r_r, r_q[VALUE_WIDTH-1]};
    assign w_sub = w_rem - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(VALUE_WIDTH);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_a[VALUE_WIDTH-1] ? -i_a : i_a;
            r_d   <= i_b[VALUE_WIDTH-1] ? -i_b : i_b;
            r_r   <= '0;
            r_neg <= i_a[VALUE_WIDTH-1] ^ i_b[VALUE_WIDTH-1];
        end else if (r_busy) begin
            if (!w_sub[VALUE_WIDTH]) begin
                r_r <= w_sub[VALUE_WIDTH-1:0];
                r_q <= {r_q[VALUE_WIDTH-2:0], 1'b1};
            end else begin
                r_r <= w_rem[VALUE_WIDTH-1:0];
                r_q <= {r_q[VALUE_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done = !r_busy;
    assign o_q    = r_neg ? -r_q : r_q;
endmodule

// ===== design/iee_datapath.sv =====
module iee_datapath import iee_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_char_in,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [VALUE_WIDTH-1:0] r_vstk [STACK_DEPTH];
    t_op                    r_ostk [STACK_DEPTH];
    logic [CW-1:0]          r_vcnt, r_ocnt;
    logic [VALUE_WIDTH-1:0] r_acc, r_a, r_b, r_top;
    logic                   r_pend;
    t_status                r_err;
    logic [7:0]             r_ch;
    t_op                    r_rop;
    logic [31:0]            r_value;
    logic [1:0]             r_status;

    logic [VALUE_WIDTH-1:0] w_res, w_q, w_push;
    logic                   w_vpush, w_dd;
    t_op                    w_cop;

    iee_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_a    (r_a),
        .i_b    (r_b),
        .o_done (w_dd),
        .o_q    (w_q)
    );

    always_comb begin
        unique case (r_ch)
            CH_ADD:   w_cop = OP_ADD;
            CH_SUB:   w_cop = OP_SUB;
            CH_MUL:   w_cop = OP_MUL;
            CH_DIV:   w_cop = OP_DIV;
            CH_OPEN:  w_cop = OP_OPEN;
            default:  w_cop = OP_NONE;
        endcase
    end

    always_comb begin
        unique case (r_rop)
            OP_ADD:  w_res = r_a + r_b;
            OP_SUB:  w_res = r_a - r_b;
            default: w_res = VALUE_WIDTH'(r_a * r_b);
        endcase
    end

    assign w_vpush = i_cmd.flush_num | i_cmd.red_exec | i_cmd.div_push;
    assign w_push  = i_cmd.flush_num ? r_acc : (i_cmd.div_push ? w_q : w_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_vcnt <= '0;
            r_ocnt <= '0;
            r_acc  <= '0;
            r_pend <= 1'b0;
            r_err  <= ST_OK;
        end else begin
            if (i_cmd.acc_digit) begin
                r_acc  <= VALUE_WIDTH'(r_acc * VALUE_WIDTH'(10))
                          + VALUE_WIDTH'(r_ch - CH_ZERO);
                r_pend <= 1'b1;
            end
            if (i_cmd.flush_num) begin
                r_acc  <= '0;
                r_pend <= 1'b0;
            end
            if (i_cmd.set_err && r_err == ST_OK) r_err <= i_cmd.err_code;
            if (i_cmd.red_pop) r_vcnt <= r_vcnt - CW'(2);
            if (w_vpush) r_vcnt <= r_vcnt + 1'b1;
            if (i_cmd.red_pop) r_ocnt <= r_ocnt - 1'b1;
            else if (i_cmd.pop_op) r_ocnt <= r_ocnt - 1'b1;
            else if (i_cmd.push_op) r_ocnt <= r_ocnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) r_ch <= i_char_in;
        if (w_vpush) r_vstk[AW'(r_vcnt)] <= w_push;
        if (i_cmd.push_op) r_ostk[AW'(r_ocnt)] <= w_cop;
        if (i_cmd.red_pop) begin
            r_b   <= r_vstk[AW'(r_vcnt - 1'b1)];
            r_a   <= r_vstk[AW'(r_vcnt - CW'(2))];
            r_rop <= r_ostk[AW'(r_ocnt - 1'b1)];
        end
        r_top <= r_vstk[0];
        if (i_cmd.emit) begin
            r_status <= r_err;
            r_value  <= (r_err == ST_OK) ? 32'(signed'(r_top)) : '0;
        end
    end

    assign o_stat.is_digit    = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign o_stat.char_op     = w_cop;
    assign o_stat.is_hash     = (r_ch == CH_HASH);
    assign o_stat.is_close    = (r_ch == CH_CLOSE);
    assign o_stat.bad_char    = (w_cop == OP_NONE) && (r_ch != CH_HASH)
                                && (r_ch != CH_CLOSE)
                                && !((r_ch >= CH_ZERO) && (r_ch <= CH_NINE));
    assign o_stat.num_pending = r_pend;
    assign o_stat.err_any     = (r_err != ST_OK);
    assign o_stat.op_empty    = (r_ocnt == '0);
    assign o_stat.op_full     = (r_ocnt == CW'(STACK_DEPTH));
    assign o_stat.op_top      = r_ostk[AW'(r_ocnt - 1'b1)];
    assign o_stat.val_lt2     = (r_vcnt < CW'(2));
    assign o_stat.val_full    = (r_vcnt == CW'(STACK_DEPTH));
    assign o_stat.val_one     = (r_vcnt == CW'(1));
    assign o_stat.div_zero    = (r_b == '0);
    assign o_stat.div_done    = w_dd;
    assign o_stat.red_op      = r_rop;
    assign o_value            = r_value;
    assign o_status           = r_status;
endmodule

// ===== design/iee_ctrl.sv =====
module iee_ctrl import iee_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_end_of_text,
    output logic  o_stall,
    input  logic  i_out_stall,
    output logic  o_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic   r_skip, n_skip, r_last, r_ovalid, w_fire;

    assign w_fire  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_out_stall);
    assign o_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= K_OPER;
            r_skip   <= 1'b1;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_skip  <= n_skip;
            if (w_fire) r_last <= i_end_of_text;
            if (o_cmd.emit) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_skip  = r_skip;
        unique case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    if (r_skip) begin
                        n_skip  = 1'b0;
                        n_state = i_end_of_text ? S_FIN_CHECK : S_IDLE;
                    end else begin
                        n_state = S_DISPATCH;
                    end
                end
            end
            S_DISPATCH: begin
                if (i_stat.err_any) begin
                    n_state = (i_stat.is_hash || r_last) ? S_EMIT : S_IDLE;
                end else if (i_stat.is_digit) begin
                    n_state = r_last ? S_FIN_LOOP : S_IDLE;
                    n_kind  = K_FIN;
                end else if (i_stat.is_hash) begin
                    n_state = S_FIN_LOOP;
                    n_kind  = K_FIN;
                end else if (i_stat.is_close) begin
                    n_state = S_CLOSE_LOOP;
                    n_kind  = K_CLOSE;
                end else if (i_stat.char_op == OP_OPEN || i_stat.bad_char) begin
                    n_state = r_last ? S_FIN_LOOP : S_IDLE;
                    n_kind  = K_FIN;
                end else begin
                    n_state = S_OP_LOOP;
                    n_kind  = K_OPER;
                end
            end
            S_OP_LOOP: begin
                if (i_stat.err_any) n_state = r_last ? S_FIN_LOOP : S_IDLE;
                else if (!i_stat.op_empty
                         && prec(i_stat.op_top) >= prec(i_stat.char_op))
                    n_state = S_RED_POP;
                else begin
                    n_state = r_last ? S_FIN_LOOP : S_IDLE;
                    n_kind  = K_FIN;
                end
            end
            S_CLOSE_LOOP: begin
                if (i_stat.err_any) n_state = r_last ? S_FIN_LOOP : S_IDLE;
                else if (!i_stat.op_empty && i_stat.op_top != OP_OPEN)
                    n_state = S_RED_POP;
                else begin
                    n_state = r_last ? S_FIN_LOOP : S_IDLE;
                    n_kind  = K_FIN;
                end
            end
            S_FIN_LOOP: begin
                if (!i_stat.err_any && i_stat.num_pending) n_state = S_FIN_LOOP;
                else if (i_stat.err_any || i_stat.op_empty) n_state = S_FIN_CHECK;
                else if (i_stat.op_top == OP_OPEN) n_state = S_FIN_CHECK;
                else n_state = S_RED_POP;
            end
            S_RED_POP: begin
                n_state = i_stat.val_lt2 ? r_state : S_RED_EXEC;
                if (i_stat.val_lt2) begin
                    unique case (r_kind)
                        K_OPER:  n_state = r_last ? S_FIN_LOOP : S_IDLE;
                        K_CLOSE: n_state = r_last ? S_FIN_LOOP : S_IDLE;
                        default: n_state = S_FIN_CHECK;
                    endcase
                end
            end
            S_RED_EXEC: begin
                if (i_stat.red_op == OP_DIV && !i_stat.div_zero) n_state = S_DIV_RUN;
                else begin
                    unique case (r_kind)
                        K_OPER:  n_state = S_OP_LOOP;
                        K_CLOSE: n_state = S_CLOSE_LOOP;
                        default: n_state = S_FIN_LOOP;
                    endcase
                end
            end
            S_DIV_RUN: begin
                if (i_stat.div_done) begin
                    unique case (r_kind)
                        K_OPER:  n_state = S_OP_LOOP;
                        K_CLOSE: n_state = S_CLOSE_LOOP;
                        default: n_state = S_FIN_LOOP;
                    endcase
                end
            end
            S_FIN_CHECK: n_state = S_EMIT;
            S_EMIT: begin
                n_state = S_IDLE;
                n_skip  = 1'b1;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.err_code = ST_OK;
        o_cmd.load_char = w_fire;
        unique case (r_state)
            S_DISPATCH: begin
                if (!i_stat.err_any) begin
                    if (i_stat.is_digit) o_cmd.acc_digit = 1'b1;
                    else if (i_stat.num_pending) begin
                        if (i_stat.val_full) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = ST_STACK;
                        end else o_cmd.flush_num = 1'b1;
                    end
                    if (!i_stat.is_digit && !(i_stat.num_pending && i_stat.val_full)) begin
                        if (i_stat.bad_char) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = ST_BAD_CHAR;
                        end else if (i_stat.char_op == OP_OPEN) begin
                            if (i_stat.op_full) begin
                                o_cmd.set_err  = 1'b1;
                                o_cmd.err_code = ST_STACK;
                            end else o_cmd.push_op = 1'b1;
                        end
                    end
                end
            end
            S_OP_LOOP: begin
                if (!i_stat.err_any && !(!i_stat.op_empty
                    && prec(i_stat.op_top) >= prec(i_stat.char_op))) begin
                    if (i_stat.op_full) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_STACK;
                    end else o_cmd.push_op = 1'b1;
                end
            end
            S_CLOSE_LOOP: begin
                if (!i_stat.err_any) begin
                    if (i_stat.op_empty) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_STACK;
                    end else if (i_stat.op_top == OP_OPEN) o_cmd.pop_op = 1'b1;
                end
            end
            S_FIN_LOOP: begin
                if (!i_stat.err_any && i_stat.num_pending) begin
                    if (i_stat.val_full) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_STACK;
                    end else o_cmd.flush_num = 1'b1;
                end else if (!i_stat.err_any && !i_stat.op_empty
                             && i_stat.op_top == OP_OPEN) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_STACK;
                end
            end
            S_RED_POP: begin
                if (i_stat.val_lt2) begin
                    o_cmd.pop_op   = 1'b1;
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_STACK;
                end else o_cmd.red_pop = 1'b1;
            end
            S_RED_EXEC: begin
                if (i_stat.red_op == OP_DIV) begin
                    if (i_stat.div_zero) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_DIV_ZERO;
                    end else o_cmd.div_start = 1'b1;
                end else o_cmd.red_exec = 1'b1;
            end
            S_DIV_RUN: o_cmd.div_push = i_stat.div_done;
            S_FIN_CHECK: begin
                if (!i_stat.err_any && !i_stat.val_one) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_STACK;
                end
            end
            S_EMIT: begin
                o_cmd.emit  = 1'b1;
                o_cmd.clear = 1'b1;
            end
            default: ;
        endcase
    end
endmodule

// ===== design/infix_expression_evaluator.sv =====
// Character-serial infix evaluator with a value stack and an operator stack in
// flip-flops. The first character of each expression is taken as the opening
// delimiter; '#' or end_of_text closes it and one transaction with value and
// status is presented. An operator or ')' runs its reductions, and a division
// uses the bit-serial restoring divider; closing an expression runs the
// reductions still pending. The result register is refilled only after it has
// been taken; while it is held the input is stalled.
module infix_expression_evaluator import iee_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);
    t_cmd  w_cmd;
    t_stat w_stat;

    iee_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_end_of_text(i_end_of_text),
        .o_stall      (o_stall),
        .i_out_stall  (i_stall),
        .o_valid      (o_valid),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    iee_datapath #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char_in(i_char_in),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_value  (o_value),
        .o_status (o_status)
    );
endmodule

// ===== design/iee_checker.sv =====
module iee_checker import iee_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_value,
    input logic [1:0]  o_status
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_status))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_value == 32'd0)
        else $error("non-zero value with error status");

    a_taken_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("result presented twice");

    a_blocked_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while result held");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind infix_expression_evaluator iee_checker u_chk (.*);

// ===== verif/infix_expression_evaluator_tb.sv =====
`timescale 1ns / 100ps

module infix_expression_evaluator_tb;
    import iee_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_txn;

    typedef struct packed {
        logic [31:0] value;
        t_status     status;
    } t_eval_txn;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_char_in;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_value;
    logic [1:0]  o_status;

    infix_expression_evaluator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_char_in(i_char_in), .i_end_of_text(i_end_of_text), .o_valid(o_valid),
        .i_stall(i_stall), .o_value(o_value), .o_status(o_status)
    );

    t_char_txn char_queue[$];
    t_eval_txn result_queue[$];
    int        n_errors;
    int        n_chars_sent;
    int        n_results_seen;
    int        n_status_seen[4];
    bit        stim_done;
    bit        hold_output;
    bit        accepted_q;
    int        send_gap;
    int        stall_cnt;

    // evaluator shadow state
    logic [31:0] vals[DEPTH];
    t_op         ops[DEPTH];
    int          n_vals;
    int          n_ops;
    logic [31:0] acc;
    bit          acc_pending;
    bit          at_start;
    t_status     err;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int op_rank(t_op op);
        if (op == OP_MUL || op == OP_DIV) return 2;
        if (op == OP_ADD || op == OP_SUB) return 1;
        return 0;
    endfunction

    function automatic void flag(t_status s);
        if (err == ST_OK) err = s;
    endfunction

    function automatic void clear_eval();
        n_vals = 0;
        n_ops = 0;
        acc = '0;
        acc_pending = 0;
        at_start = 1;
        err = ST_OK;
    endfunction

    function automatic void push_val(logic [31:0] v);
        if (n_vals >= DEPTH) flag(ST_STACK);
        else begin
            vals[n_vals] = v;
            n_vals++;
        end
    endfunction

    function automatic void push_oper(t_op op);
        if (n_ops >= DEPTH) flag(ST_STACK);
        else begin
            ops[n_ops] = op;
            n_ops++;
        end
    endfunction

    function automatic void apply_op(t_op op);
        logic signed [31:0] a, b;
        logic [31:0] r;
        if (n_vals < 2) begin
            flag(ST_STACK);
            return;
        end
        b = vals[n_vals - 1];
        a = vals[n_vals - 2];
        n_vals -= 2;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV: begin
                if (b == 0) begin
                    flag(ST_DIV_ZERO);
                    return;
                end
                if (a == 32'sh8000_0000 && b == -1) r = a;
                else r = a / b;
            end
            default: begin
                flag(ST_STACK);
                return;
            end
        endcase
        push_val(r);
    endfunction

    function automatic void flush_acc();
        if (acc_pending) begin
            push_val(acc);
            acc_pending = 0;
            acc = '0;
        end
    endfunction

    function automatic t_eval_txn close_expr();
        t_eval_txn res;
        t_op op;
        if (err == ST_OK) flush_acc();
        while (err == ST_OK && n_ops > 0) begin
            n_ops--;
            op = ops[n_ops];
            if (op == OP_OPEN) flag(ST_STACK);
            else apply_op(op);
        end
        if (err == ST_OK && n_vals != 1) flag(ST_STACK);
        res.value = (err == ST_OK) ? vals[0] : '0;
        res.status = err;
        clear_eval();
        return res;
    endfunction

    function automatic void take_operator(t_op op);
        t_op top;
        while (err == ST_OK && n_ops > 0 && op_rank(ops[n_ops - 1]) >= op_rank(op)) begin
            n_ops--;
            top = ops[n_ops];
            apply_op(top);
        end
        if (err == ST_OK) push_oper(op);
    endfunction

    function automatic void take_close();
        t_op top;
        while (err == ST_OK && n_ops > 0 && ops[n_ops - 1] != OP_OPEN) begin
            n_ops--;
            top = ops[n_ops];
            apply_op(top);
        end
        if (err != ST_OK) return;
        if (n_ops == 0) flag(ST_STACK);
        else n_ops--;
    endfunction

    // returns 1 when the character closes an expression
    function automatic bit eval_char(t_char_txn t, output t_eval_txn res);
        res = '0;
        if (at_start) begin
            at_start = 0;
            if (t.last) begin
                res = close_expr();
                return 1;
            end
            return 0;
        end
        if (err == ST_OK) begin
            if (t.ch >= CH_ZERO && t.ch <= CH_NINE) begin
                acc = acc * 10 + 32'(t.ch - CH_ZERO);
                acc_pending = 1;
            end else begin
                flush_acc();
                if (t.ch == CH_HASH) begin
                    res = close_expr();
                    return 1;
                end
                if (err == ST_OK) begin
                    case (t.ch)
                        CH_ADD:   take_operator(OP_ADD);
                        CH_SUB:   take_operator(OP_SUB);
                        CH_MUL:   take_operator(OP_MUL);
                        CH_DIV:   take_operator(OP_DIV);
                        CH_OPEN:  push_oper(OP_OPEN);
                        CH_CLOSE: take_close();
                        default:  flag(ST_BAD_CHAR);
                    endcase
                end
            end
        end else if (t.ch == CH_HASH) begin
            res = close_expr();
            return 1;
        end
        if (t.last) begin
            res = close_expr();
            return 1;
        end
        return 0;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic void add_char(logic [7:0] ch, bit last = 0);
        t_char_txn t;
        t.ch = ch;
        t.last = last;
        char_queue.push_back(t);
    endfunction

    function automatic void add_text(string s, bit last_flag = 0);
        for (int k = 0; k < s.len(); k++)
            add_char(s[k], last_flag && k == s.len() - 1);
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_oper();
        case ($urandom_range(0, 3))
            0: return CH_ADD;
            1: return CH_SUB;
            2: return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    // well-formed expression with random content, optionally broken
    function automatic void add_rand_expr();
        int terms, depth_open, nd;
        bit noisy;
        terms = $urandom_range(1, 6);
        depth_open = 0;
        noisy = ($urandom_range(0, 5) == 0);
        add_char(CH_HASH);
        for (int k = 0; k < terms; k++) begin
            if (depth_open < 4 && $urandom_range(0, 3) == 0) begin
                add_char(CH_OPEN);
                depth_open++;
            end
            nd = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 11) : $urandom_range(1, 3);
            for (int d = 0; d < nd; d++) add_char(rand_digit());
            if (depth_open > 0 && $urandom_range(0, 2) == 0) begin
                add_char(CH_CLOSE);
                depth_open--;
            end
            if (noisy && $urandom_range(0, 3) == 0) add_char(8'($urandom_range(0, 255)));
            if (k != terms - 1) add_char(rand_oper());
        end
        while (depth_open > 0 && !(noisy && $urandom_range(0, 1))) begin
            add_char(CH_CLOSE);
            depth_open--;
        end
        if ($urandom_range(0, 1)) add_char(CH_HASH, $urandom_range(0, 3) == 0);
        else add_char(rand_digit(), 1);
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_char_in = '0;
        i_end_of_text = 1'b0;
        i_stall = 1'b1;
        n_errors = 0;
        n_chars_sent = 0;
        n_results_seen = 0;
        stim_done = 0;
        hold_output = 0;
        accepted_q = 0;
        clear_eval();
        add_char(CH_HASH, 1);
        add_text("#2147483647*2+1#");
        add_text("#(8+2*3)/(1-4)-7#");
        add_text("#5/0#");
        add_text("#9+)#");
        add_text("#(3+4#");
        add_text("#3 4#");
        add_text("#++#");
        add_text("#0-2147483648/1", 1);
        add_char(8'hff);
        add_char(8'h00, 1);
        add_text("#4294967296-1#");
        add_text("#((((((((((((((((((1#");
        add_text("#1+(2+(3+(4+(5+(6+(7+(8+(9+(1+(2+(3+(4+(5+(6+(7+(8+9#");
        add_text("#1-1-1*2/2-5#", 1);
        repeat (28) add_rand_expr();
        for (int k = 0; k < 40; k++) add_char(8'($urandom_range(0, 255)), k == 39);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // sender
    initial send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || accepted_q) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (char_queue.size() > 0) begin
                    t_char_txn t;
                    t = char_queue.pop_front();
                    i_char_in <= t.ch;
                    i_end_of_text <= t.last;
                    i_valid <= 1'b1;
                    send_gap <= gap_len();
                end else begin
                    i_valid <= 1'b0;
                    stim_done <= 1;
                end
            end
        end
    end

    // capture handshakes at the rising edge
    always @(posedge i_clk) begin
        t_eval_txn res, want;
        accepted_q <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            t_char_txn t;
            t.ch = i_char_in;
            t.last = i_end_of_text;
            n_chars_sent++;
            if (eval_char(t, res)) result_queue.push_back(res);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            n_results_seen++;
            if (result_queue.size() == 0) begin
                report_mismatch("unexpected result", o_value, '0);
            end else begin
                want = result_queue.pop_front();
                n_status_seen[want.status]++;
                if (o_value !== want.value) report_mismatch("value", o_value, want.value);
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
            end
        end
    end

    // receiver stall, with one long hold-off
    initial stall_cnt = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b1;
        else if (n_chars_sent > 60 && n_chars_sent < 70 && !hold_output) begin
            hold_output <= 1;
            stall_cnt <= 400;
            i_stall <= 1'b1;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_cnt <= gap_len();
            i_stall <= 1'b1;
        end else i_stall <= 1'b0;
    end

    initial begin
        @(posedge i_rst_n);
        wait (stim_done && result_queue.size() == 0);
        repeat (400) @(posedge i_clk);
        $display("covered %0d characters and %0d expressions", n_chars_sent, n_results_seen);
        $display("status mix ok/div0/stack/bad: %0d/%0d/%0d/%0d",
                 n_status_seen[0], n_status_seen[1], n_status_seen[2], n_status_seen[3]);
        if (n_errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule
